// File: sv/slip_frame_decoder_unit_macros.svh
// ---------------------------------------------------------------------------
// SLIP frame decoder assertion macros
// Wrappers for concurrent checks; empty bodies when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SLIP_FRAME_DECODER_UNIT_MACROS_SVH
`define SLIP_FRAME_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication under reset.
`define SFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfd assertion failed");

// Next-cycle implication under reset.
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfd assertion failed");

`else

`define SFD_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/sfd_pkg.sv
// ---------------------------------------------------------------------------
// SLIP frame decoder package
// Delimiter codes, field widths and the item types shared by all stages.
// ---------------------------------------------------------------------------
package sfd_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 16;

	localparam logic [BYTE_W-1:0] FEND  = 8'hC0;
	localparam logic [BYTE_W-1:0] FESC  = 8'hDB;
	localparam logic [BYTE_W-1:0] TFEND = 8'hDC;
	localparam logic [BYTE_W-1:0] TFESC = 8'hDD;

	localparam int MIN_FRAME_LEN = 3;
	localparam logic [LEN_W-1:0] POS_MAX = {LEN_W{1'b1}};

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              is_last;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              data_valid;
		logic              frame_done;
		logic              frame_ok;
		logic [LEN_W-1:0]  decoded_len;
	} out_item_t;

	// Input register contents handed to the decode stage.
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} stage_t;

endpackage

// File: sv/sfd_if.sv
// ---------------------------------------------------------------------------
// SLIP frame decoder channels
// Valid/ready channels for raw frame bytes and decoded results.
// ---------------------------------------------------------------------------
interface sfd_in_if;
	import sfd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              is_last;

	modport source (output valid, output in_byte, output is_last, input ready);
	modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface sfd_out_if;
	import sfd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              data_valid;
	logic              frame_done;
	logic              frame_ok;
	logic [LEN_W-1:0]  decoded_len;

	modport source (output valid, output out_byte, output data_valid, output frame_done,
		output frame_ok, output decoded_len, input ready);
	modport sink   (input valid, input out_byte, input data_valid, input frame_done,
		input frame_ok, input decoded_len, output ready);
endinterface

// File: sv/sfd_in_stage.sv
// ---------------------------------------------------------------------------
// SLIP frame decoder input stage
// Registers one raw byte; refills in the same cycle the decoder takes it.
// ---------------------------------------------------------------------------
module sfd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	sfd_in_if.sink            rx,
	input  logic              take,
	output sfd_pkg::stage_t   s1
);
	import sfd_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;
	logic     accept;

	assign rx.ready = !valid_s1 || take;
	assign accept   = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.in_byte <= rx.in_byte;
			item_s1.is_last <= rx.is_last;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.item  = item_s1;
endmodule

// File: sv/sfd_decode.sv
// ---------------------------------------------------------------------------
// SLIP frame decoder core
// Holds per-frame state, unescapes one byte and forms at most one result.
// ---------------------------------------------------------------------------
module sfd_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  sfd_pkg::in_item_t   item,
	output logic                res_valid,
	output sfd_pkg::out_item_t  res
);
	import sfd_pkg::*;

	`include "slip_frame_decoder_unit_macros.svh"

	logic [LEN_W-1:0]  pos_q, pos_n;
	logic [LEN_W-1:0]  cnt_q, cnt_n;
	logic              esc_q, esc_n;
	logic              start_q, start_n;
	logic              ovf_q, ovf_n;
	logic              pos_max;
	logic              frame_ok;
	logic              emit;
	logic [BYTE_W-1:0] dat;

	always_comb begin
		pos_max   = (pos_q == POS_MAX);
		ovf_n     = ovf_q || pos_max;
		pos_n     = pos_q;
		cnt_n     = cnt_q;
		esc_n     = esc_q;
		start_n   = start_q;
		emit      = 1'b0;
		dat       = '0;
		frame_ok  = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		if (item.is_last) begin
			// Close the frame: report and clear everything.
			frame_ok = (pos_q >= LEN_W'(MIN_FRAME_LEN - 1)) && start_q &&
				(item.in_byte == FEND) && !esc_q && !ovf_n;
			res_valid        = 1'b1;
			res.frame_done   = 1'b1;
			res.frame_ok     = frame_ok;
			res.decoded_len  = frame_ok ? cnt_q : '0;
			pos_n   = '0;
			cnt_n   = '0;
			esc_n   = 1'b0;
			start_n = 1'b0;
			ovf_n   = 1'b0;
		end else begin
			if (!pos_max) begin
				pos_n = pos_q + LEN_W'(1);
			end
			if (pos_q == '0) begin
				start_n = (item.in_byte == FEND);
			end else if (!ovf_n) begin
				if (esc_q) begin
					esc_n = 1'b0;
					if (item.in_byte == TFEND) begin
						emit = 1'b1;
						dat  = FEND;
					end else if (item.in_byte == TFESC) begin
						emit = 1'b1;
						dat  = FESC;
					end
				end else if (item.in_byte == FESC) begin
					esc_n = 1'b1;
				end else begin
					emit = 1'b1;
					dat  = item.in_byte;
				end
				if (emit && start_q) begin
					res_valid      = 1'b1;
					res.out_byte   = dat;
					res.data_valid = 1'b1;
					if (cnt_q != POS_MAX) begin
						cnt_n = cnt_q + LEN_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			cnt_q   <= '0;
			esc_q   <= 1'b0;
			start_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (adv) begin
			pos_q   <= pos_n;
			cnt_q   <= cnt_n;
			esc_q   <= esc_n;
			start_q <= start_n;
			ovf_q   <= ovf_n;
		end
	end

	`SFD_ASSERT_NEXT(a_clear_after_last, clk, arst_n, adv && item.is_last, pos_q == '0 && cnt_q == '0 && !esc_q && !start_q)
	`SFD_ASSERT_IMPL(a_ovf_saturated, clk, arst_n, ovf_q, pos_q == POS_MAX)
	`SFD_ASSERT_IMPL(a_count_below_pos, clk, arst_n, 1'b1, cnt_q <= pos_q)
	`SFD_ASSERT_IMPL(a_no_count_bad_start, clk, arst_n, !start_q, cnt_q == '0)
endmodule

// File: sv/sfd_out_stage.sv
// ---------------------------------------------------------------------------
// SLIP frame decoder output stage
// Result register; refills in the same cycle its item is taken.
// ---------------------------------------------------------------------------
module sfd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  sfd_pkg::out_item_t  res,
	output logic                free,
	sfd_out_if.source           tx
);
	import sfd_pkg::*;

	logic      valid_s2;
	out_item_t item_s2;

	assign free = !valid_s2 || tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (tx.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= res;
		end
	end

	assign tx.valid       = valid_s2;
	assign tx.out_byte    = item_s2.out_byte;
	assign tx.data_valid  = item_s2.data_valid;
	assign tx.frame_done  = item_s2.frame_done;
	assign tx.frame_ok    = item_s2.frame_ok;
	assign tx.decoded_len = item_s2.decoded_len;
endmodule

// File: sv/slip_frame_decoder_unit.sv
// ---------------------------------------------------------------------------
// SLIP frame decoder unit
// Streaming SLIP unescaper with per-frame length and validity report.
// ---------------------------------------------------------------------------
// A result passes the input register and then the result register before it is
//   offered; while the result register is full it waits in the input register.
// Throughput: one byte per cycle; the input register and the result register
//   are both refilled in the cycle they are emptied, so stalls only back up.
// Bytes that decode to nothing (first byte, escape, bad escape, overflow, bytes of
//   a frame not opened by FEND) give no result and leave the output untouched.
// Reset (arst_n low): both stage registers empty and all frame state cleared.
module slip_frame_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	sfd_in_if.sink     rx,
	sfd_out_if.source  tx
);
	import sfd_pkg::*;

	stage_t    s1;
	out_item_t res;
	logic      res_valid;
	logic      out_free;
	logic      adv;

	// Advance the held byte whenever the result register can take what it yields;
	// a silent byte needs the same slot to keep ordering simple.
	assign adv = s1.valid && out_free;

	// Input register: byte and last flag.
	sfd_in_stage u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.take   (adv),
		.s1     (s1)
	);

	// Frame state and unescape logic.
	sfd_decode u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item      (s1.item),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register: load only when the byte produced a result.
	sfd_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv && res_valid),
		.res    (res),
		.free   (out_free),
		.tx     (tx)
	);
endmodule
